### design/ucf_pkg.sv
// Shared package for the undirected cycle finder.
// Holds the fixed field widths, the operation codes and the command and status
// structures between the controller and the datapath; depends on nothing.
package ucf_pkg;

    localparam int NODE_W = 6;
    localparam int OP_W   = 2;
    localparam int LEN_W  = 6;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic add;
        logic clear;
        logic init;
        logic root_next;
        logic root_push;
        logic edge_rd;
        logic edge_eval;
        logic pop;
        logic top_load;
        logic cyc_setup;
        logic em_issue;
        logic em_load;
        logic nc_load;
    } cmd_t;

    typedef struct packed {
        logic root_over;
        logic root_visited;
        logic scan_more;
        logic last_on_stack;
        logic cand_new;
        logic cand_active;
        logic em_last;
        logic out_free;
    } sts_t;

endpackage

### design/ucf_ctrl.sv
// Controller state machine of the undirected cycle finder.
// Sequences the item handshake, the depth-first walk and the result emission;
// depends on ucf_pkg.
module ucf_ctrl
    import ucf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic [OP_W-1:0] op,
    output logic            s_tready,
    input  sts_t            sts,
    output cmd_t            cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_SCAN,
        ST_EDGE,
        ST_POPW,
        ST_CYC,
        ST_EMRD,
        ST_EMOUT
    } state_t;

    state_t state_reg, state_next;
    logic   nocyc_reg, nocyc_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        nocyc_next = nocyc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (op)
                        OP_ADD:   cmd.add = 1'b1;
                        OP_CLEAR: cmd.clear = 1'b1;
                        OP_SEARCH:
                        begin
                            cmd.init   = 1'b1;
                            state_next = ST_ROOT;
                        end
                        default:  ;
                    endcase
                end
            end
            ST_ROOT:
            begin
                if (sts.root_over)
                begin
                    nocyc_next = 1'b1;
                    state_next = ST_EMOUT;
                end
                else if (sts.root_visited)
                    cmd.root_next = 1'b1;
                else
                begin
                    cmd.root_push = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_more)
                begin
                    cmd.edge_rd = 1'b1;
                    state_next  = ST_EDGE;
                end
                else
                begin
                    cmd.pop = 1'b1;
                    if (sts.last_on_stack)
                    begin
                        cmd.root_next = 1'b1;
                        state_next    = ST_ROOT;
                    end
                    else
                        state_next = ST_POPW;
                end
            end
            ST_EDGE:
            begin
                cmd.edge_eval = 1'b1;
                if (sts.cand_active && !sts.cand_new)
                    state_next = ST_CYC;
                else
                    state_next = ST_SCAN;
            end
            ST_POPW:
            begin
                cmd.top_load = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_CYC:
            begin
                cmd.cyc_setup = 1'b1;
                nocyc_next    = 1'b0;
                state_next    = ST_EMRD;
            end
            ST_EMRD:
            begin
                cmd.em_issue = 1'b1;
                state_next   = ST_EMOUT;
            end
            ST_EMOUT:
            begin
                if (sts.out_free)
                begin
                    if (nocyc_reg)
                    begin
                        cmd.nc_load = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        cmd.em_load = 1'b1;
                        state_next  = sts.em_last ? ST_IDLE : ST_EMRD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nocyc_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nocyc_reg <= nocyc_next;
        end
    end

endmodule

### design/ucf_datapath.sv
// Datapath of the undirected cycle finder.
// Holds the edge store, walk stack, depth table, node marks, walk registers and
// the output register; acts on commands from ucf_ctrl; depends on ucf_pkg.
module ucf_datapath
    import ucf_pkg::*;
#(
    parameter int MAX_NODES = 32,
    parameter int MAX_EDGES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [NODE_W-1:0] end_a,
    input  logic [NODE_W-1:0] end_b,
    input  logic              cfg_valid,
    input  logic [NODE_W-1:0] cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_found,
    output logic [NODE_W-1:0] out_node,
    output logic [LEN_W-1:0]  out_len,
    output logic              out_dropped,
    output logic              out_last
);

    localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECNT_W = $clog2(MAX_EDGES + 1);
    localparam int NIDX_W = $clog2(MAX_NODES + 1);
    localparam int SIDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int SP_W   = $clog2(MAX_NODES + 1);

    // Edge store and walk memories.
    logic [2*NODE_W-1:0] edge_mem [MAX_EDGES];
    logic [2*NODE_W-1:0] nstk_mem [MAX_NODES];
    logic [ECNT_W-1:0]   cstk_mem [MAX_NODES];
    logic [SIDX_W-1:0]   dep_mem  [MAX_NODES + 1];

    logic [2*NODE_W-1:0] edge_rd_reg;
    logic [2*NODE_W-1:0] nstk_rd_reg;
    logic [ECNT_W-1:0]   cstk_rd_reg;
    logic [SIDX_W-1:0]   dep_rd_reg;

    logic [NODE_W-1:0]   node_count_reg;
    logic [ECNT_W-1:0]   edge_total_reg;
    logic                dropped_reg;
    logic [MAX_NODES:0]  visited_reg;
    logic [MAX_NODES:0]  active_reg;
    logic [NODE_W:0]     root_reg;
    logic [SP_W-1:0]     sp_reg;
    logic [NODE_W-1:0]   u_reg;
    logic [NODE_W-1:0]   pu_reg;
    logic [ECNT_W-1:0]   i_reg;
    logic [NODE_W-1:0]   w_reg;
    logic [SIDX_W-1:0]   k_reg;
    logic [SIDX_W-1:0]   stop_reg;
    logic [SP_W:0]       len_reg;
    logic [1:0]          phase_reg;
    logic                out_valid_reg;
    logic                out_found_reg;
    logic [NODE_W-1:0]   out_node_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic                out_dropped_reg;
    logic                out_last_reg;

    logic [NODE_W-1:0]   n;
    logic                drop;
    logic [NODE_W-1:0]   ea, eb, w;
    logic                adj_a, adjacent, cand;
    logic [NIDX_W-1:0]   widx, ridx;
    logic [SIDX_W-1:0]   stk_top;
    logic [SIDX_W-1:0]   stk_new;
    logic [SIDX_W-1:0]   stk_raddr;

    // A node count above the supported maximum acts as the maximum.
    assign n = (32'(node_count_reg) > MAX_NODES) ? NODE_W'(MAX_NODES) : node_count_reg;

    assign drop = (32'(edge_total_reg) >= MAX_EDGES) || (end_a == '0) || (end_b == '0)
                  || (end_a > n) || (end_b > n) || (end_a == end_b);

    assign ea       = edge_rd_reg[NODE_W-1:0];
    assign eb       = edge_rd_reg[2*NODE_W-1:NODE_W];
    assign adj_a    = (ea == u_reg);
    assign adjacent = adj_a || (eb == u_reg);
    assign w        = adj_a ? eb : ea;
    assign cand     = adjacent && (w != '0) && (w <= n) && (w != pu_reg);
    assign widx     = NIDX_W'(w);
    assign ridx     = NIDX_W'(root_reg);
    assign stk_top  = SIDX_W'(sp_reg - SP_W'(1));
    assign stk_new  = SIDX_W'(sp_reg);
    assign stk_raddr = cmd.em_issue ? k_reg : SIDX_W'(sp_reg - SP_W'(2));

    always_comb
    begin
        sts               = '0;
        sts.root_over     = (root_reg > {1'b0, n});
        sts.root_visited  = visited_reg[ridx];
        sts.scan_more     = (i_reg < edge_total_reg);
        sts.last_on_stack = (sp_reg == SP_W'(1));
        sts.cand_new      = cand && !visited_reg[widx];
        sts.cand_active   = cand && visited_reg[widx] && active_reg[widx];
        sts.em_last       = (phase_reg == 2'd2);
        sts.out_free      = !out_valid_reg || out_ready;
    end

    // Memories and payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.add && !drop)
            edge_mem[edge_total_reg[EIDX_W-1:0]] <= {end_b, end_a};
        if (cmd.edge_rd)
            edge_rd_reg <= edge_mem[i_reg[EIDX_W-1:0]];
        if (cmd.root_push)
        begin
            nstk_mem[0]   <= {NODE_W'(0), NODE_W'(root_reg)};
            dep_mem[ridx] <= '0;
        end
        if (cmd.edge_eval && sts.cand_new)
        begin
            nstk_mem[stk_new] <= {u_reg, w};
            cstk_mem[stk_top] <= i_reg + ECNT_W'(1);
            dep_mem[widx]     <= stk_new;
        end
        if (cmd.pop || cmd.em_issue)
        begin
            nstk_rd_reg <= nstk_mem[stk_raddr];
            cstk_rd_reg <= cstk_mem[stk_raddr];
        end
        dep_rd_reg <= dep_mem[widx];

        if (cmd.root_push)
        begin
            u_reg  <= NODE_W'(root_reg);
            pu_reg <= '0;
        end
        if (cmd.edge_eval)
        begin
            w_reg <= w;
            if (sts.cand_new)
            begin
                u_reg  <= w;
                pu_reg <= u_reg;
            end
        end
        if (cmd.top_load)
        begin
            u_reg  <= nstk_rd_reg[NODE_W-1:0];
            pu_reg <= nstk_rd_reg[2*NODE_W-1:NODE_W];
        end
        if (cmd.cyc_setup)
        begin
            k_reg    <= stk_top;
            stop_reg <= dep_rd_reg;
            len_reg  <= {1'b0, sp_reg} + (SP_W+1)'(1) - (SP_W+1)'(dep_rd_reg);
        end
        if (cmd.em_load)
        begin
            out_found_reg   <= 1'b1;
            out_len_reg     <= LEN_W'(len_reg);
            out_dropped_reg <= dropped_reg;
            out_last_reg    <= (phase_reg == 2'd2);
            case (phase_reg)
                2'd0:    out_node_reg <= nstk_rd_reg[NODE_W-1:0];
                2'd1:    out_node_reg <= w_reg;
                default: out_node_reg <= u_reg;
            endcase
            if (phase_reg == 2'd0)
                k_reg <= k_reg - SIDX_W'(1);
        end
        if (cmd.nc_load)
        begin
            out_found_reg   <= 1'b0;
            out_node_reg    <= '0;
            out_len_reg     <= '0;
            out_dropped_reg <= dropped_reg;
            out_last_reg    <= 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_W'(32);
            edge_total_reg <= '0;
            dropped_reg    <= 1'b0;
            visited_reg    <= '0;
            active_reg     <= '0;
            root_reg       <= '0;
            sp_reg         <= '0;
            i_reg          <= '0;
            phase_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                node_count_reg <= cfg_data;
            if (cmd.add)
            begin
                if (drop)
                    dropped_reg <= 1'b1;
                else
                    edge_total_reg <= edge_total_reg + ECNT_W'(1);
            end
            if (cmd.clear)
            begin
                edge_total_reg <= '0;
                dropped_reg    <= 1'b0;
            end
            if (cmd.init)
            begin
                visited_reg <= '0;
                active_reg  <= '0;
                root_reg    <= (NODE_W+1)'(1);
            end
            if (cmd.root_next)
                root_reg <= root_reg + (NODE_W+1)'(1);
            if (cmd.root_push)
            begin
                visited_reg[ridx] <= 1'b1;
                active_reg[ridx]  <= 1'b1;
                sp_reg            <= SP_W'(1);
                i_reg             <= '0;
            end
            if (cmd.edge_eval)
            begin
                if (sts.cand_new)
                begin
                    visited_reg[widx] <= 1'b1;
                    active_reg[widx]  <= 1'b1;
                    sp_reg            <= sp_reg + SP_W'(1);
                    i_reg             <= '0;
                end
                else
                    i_reg <= i_reg + ECNT_W'(1);
            end
            if (cmd.pop)
            begin
                active_reg[NIDX_W'(u_reg)] <= 1'b0;
                sp_reg                     <= sp_reg - SP_W'(1);
            end
            if (cmd.top_load)
                i_reg <= cstk_rd_reg;
            if (cmd.cyc_setup)
                phase_reg <= 2'd0;
            // Stack entries above the closing node come first, then the
            // closing node and the current node once more.
            if (cmd.em_load)
            begin
                case (phase_reg)
                    2'd0:    if (k_reg - SIDX_W'(1) == stop_reg) phase_reg <= 2'd1;
                    2'd1:    phase_reg <= 2'd2;
                    default: phase_reg <= 2'd0;
                endcase
            end
            if (cmd.em_load || cmd.nc_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_found   = out_found_reg;
    assign out_node    = out_node_reg;
    assign out_len     = out_len_reg;
    assign out_dropped = out_dropped_reg;
    assign out_last    = out_last_reg;

endmodule

### design/undirected_cycle_finder.sv
// Undirected cycle finder. Add-edge and clear transactions are taken one per
// cycle. A search transaction holds the input for the whole depth-first walk:
// each root is tried in turn, the stored edges are read and examined at each
// scan position of the current node, the stack is popped when a node has no
// edge left, then the path is set up and each result is emitted in turn. The
// block accepts new transactions once the final result of a search sits in
// the output register. The node count register is always ready; the user is
// to write it only while the block is idle, which the block does not enforce.
module undirected_cycle_finder
    import ucf_pkg::*;
#(
    parameter int MAX_NODES = 32,
    parameter int MAX_EDGES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // operation[1:0], end_a[7:2], end_b[13:8], zero
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [NODE_W-1:0] cfg_data,  // node_count
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // found[0], node[6:1], path_length[12:7],
                                         // edge_dropped[13], zero
    output logic              m_tlast
);

    cmd_t              cmd;
    sts_t              sts;
    logic              found;
    logic [NODE_W-1:0] node;
    logic [LEN_W-1:0]  path_length;
    logic              edge_dropped;

    assign cfg_ready = 1'b1;

    ucf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .op       (s_tdata[OP_W-1:0]),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ucf_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .end_a       (s_tdata[7:2]),
        .end_b       (s_tdata[13:8]),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_found   (found),
        .out_node    (node),
        .out_len     (path_length),
        .out_dropped (edge_dropped),
        .out_last    (m_tlast)
    );

    assign m_tdata = {2'b00, edge_dropped, path_length, node, found};

endmodule

### tb/tb_undirected_cycle_finder.sv
// Self-checking testbench for the undirected cycle finder.
// Predicts every search result from its own copy of the edge store and walk,
// and depends on ucf_pkg and undirected_cycle_finder.
`timescale 1ns / 100ps

module tb_undirected_cycle_finder;
    import ucf_pkg::*;

    localparam int NODES_MAX   = 32;
    localparam int EDGES_MAX   = 64;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
    } edge_cmd_t;

    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] node;
        logic [LEN_W-1:0]  len;
        logic              dropped;
        logic              last;
    } cycle_res_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [NODE_W-1:0] cfg_data;
    logic              m_tvalid;
    logic              m_tready;
    logic [15:0]       m_tdata;
    logic              m_tlast;

    // Predictor state
    int unsigned store_a[EDGES_MAX];
    int unsigned store_b[EDGES_MAX];
    int unsigned stored_edges;
    bit          any_dropped;
    int unsigned live_nodes;

    edge_cmd_t  pending_cmds[$];
    cycle_res_t expected_path[$];
    bit         in_taken;
    bit         quiet_mode;
    int         errors;
    int         idle_count;
    int         cmd_sent;

    undirected_cycle_finder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned nodes_active();
        return (live_nodes > NODES_MAX) ? NODES_MAX : live_nodes;
    endfunction

    function automatic void push_result(bit f, int unsigned nd, int unsigned ln, bit lst);
        cycle_res_t r;
        r.found   = f;
        r.node    = nd[NODE_W-1:0];
        r.len     = ln[LEN_W-1:0];
        r.dropped = any_dropped;
        r.last    = lst;
        expected_path.insert(expected_path.size(), r);
    endfunction

    // Depth-first walk; queues the cycle path or a single no-cycle result.
    function automatic void predict_cycle();
        bit          seen[NODES_MAX+1];
        bit          on_stack[NODES_MAX+1];
        int unsigned parent[NODES_MAX+1];
        int unsigned stk_node[NODES_MAX+1];
        int unsigned stk_pos[NODES_MAX+1];
        int unsigned path[$];
        int unsigned n, sp, u, i, w, cur, cnt;
        bit          pushed;
        n = nodes_active();
        for (int k = 0; k <= NODES_MAX; k++)
        begin
            seen[k] = 0;
            on_stack[k] = 0;
            parent[k] = 0;
        end
        for (int unsigned root = 1; root <= n; root++)
        begin
            if (seen[root])
                continue;
            stk_node[0] = root;
            stk_pos[0] = 0;
            sp = 1;
            seen[root] = 1;
            on_stack[root] = 1;
            parent[root] = 0;
            while (sp > 0)
            begin
                u = stk_node[sp-1];
                i = stk_pos[sp-1];
                pushed = 0;
                while (i < stored_edges && !pushed)
                begin
                    if (store_a[i] == u)
                        w = store_b[i];
                    else if (store_b[i] == u)
                        w = store_a[i];
                    else
                    begin
                        i++;
                        continue;
                    end
                    i++;
                    if (w == 0 || w > n || w == parent[u])
                        continue;
                    if (!seen[w])
                    begin
                        stk_pos[sp-1] = i;
                        if (sp <= NODES_MAX)
                        begin
                            stk_node[sp] = w;
                            stk_pos[sp] = 0;
                            sp++;
                        end
                        seen[w] = 1;
                        on_stack[w] = 1;
                        parent[w] = u;
                        pushed = 1;
                    end
                    else if (on_stack[w])
                    begin
                        cur = u;
                        cnt = 0;
                        while (cur != w && cur != 0 && cnt < NODES_MAX)
                        begin
                            path.insert(path.size(), cur);
                            cnt++;
                            cur = parent[cur];
                        end
                        path.insert(path.size(), w);
                        path.insert(path.size(), u);
                        foreach (path[k])
                            push_result(1, path[k], path.size(), k == path.size() - 1);
                        return;
                    end
                end
                if (!pushed)
                begin
                    on_stack[u] = 0;
                    sp--;
                end
            end
        end
        push_result(0, 0, 0, 1);
    endfunction

    function automatic void predict_cmd(edge_cmd_t c);
        int unsigned n;
        n = nodes_active();
        if (c.op == OP_ADD)
        begin
            if (stored_edges >= EDGES_MAX || c.a == 0 || c.b == 0 || c.a > n || c.b > n
                || c.a == c.b)
                any_dropped = 1;
            else
            begin
                store_a[stored_edges] = c.a;
                store_b[stored_edges] = c.b;
                stored_edges++;
            end
        end
        else if (c.op == OP_CLEAR)
        begin
            stored_edges = 0;
            any_dropped = 0;
        end
        else if (c.op == OP_SEARCH)
            predict_cycle();
    endfunction

    function automatic void queue_cmd(logic [OP_W-1:0] op, int unsigned a, int unsigned b);
        edge_cmd_t c;
        c.op = op;
        c.a  = a[NODE_W-1:0];
        c.b  = b[NODE_W-1:0];
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    // Random graph with a few nodes; many searches find a cycle.
    function automatic void queue_graph(int unsigned span, int unsigned edges);
        queue_cmd(OP_CLEAR, 0, 0);
        for (int k = 0; k < edges; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                queue_cmd(OP_ADD, $urandom_range(0, 63), $urandom_range(0, 63));
            else
                queue_cmd(OP_ADD, $urandom_range(1, span), $urandom_range(1, span));
        end
        queue_cmd(OP_SEARCH, $urandom_range(0, 63), $urandom_range(0, 63));
    endfunction

    // Input driver; a presented transaction is held until it is taken.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || in_taken)
        begin
            if (pending_cmds.size() > 0 && (quiet_mode || $urandom_range(0, 99) >= 32))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, pending_cmds[0].b, pending_cmds[0].a, pending_cmds[0].op};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_cmd(pending_cmds.pop_front());
            cmd_sent++;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= quiet_mode || ($urandom_range(0, 99) >= 32);
    end

    // Result monitor
    always @(posedge clk)
    begin
        cycle_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_path.size() == 0)
            begin
                $error("unexpected result: tdata %h tlast %b", m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = expected_path.pop_front();
                if (m_tdata[0] !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[6:1] !== want.node)
                begin
                    $error("node: expected %0d, got %0d", want.node, m_tdata[6:1]);
                    errors++;
                end
                if (m_tdata[12:7] !== want.len)
                begin
                    $error("path_length: expected %0d, got %0d", want.len, m_tdata[12:7]);
                    errors++;
                end
                if (m_tdata[13] !== want.dropped)
                begin
                    $error("edge_dropped: expected %0d, got %0d", want.dropped, m_tdata[13]);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("undirected_cycle_finder regression: fail");
            $finish;
        end
    end

    task automatic write_node_count(int unsigned value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[NODE_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        live_nodes = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every queued command and expected result is through,
    // then lets a search's remaining cycles drain.
    task automatic drain();
        while (pending_cmds.size() > 0 || expected_path.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        int unsigned span;
        quiet_mode = 0;
        stored_edges = 0;
        any_dropped = 0;
        live_nodes = 32;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty search, triangle, dropped edges, repeated edge, bad opcode
        queue_cmd(OP_SEARCH, 0, 0);
        queue_cmd(OP_ADD, 1, 2);
        queue_cmd(OP_ADD, 1, 2);
        queue_cmd(OP_SEARCH, 63, 63);
        queue_cmd(OP_ADD, 2, 3);
        queue_cmd(OP_ADD, 3, 1);
        queue_cmd(OP_ADD, 0, 5);
        queue_cmd(OP_ADD, 5, 5);
        queue_cmd(OP_ADD, 33, 4);
        queue_cmd(OP_ADD, 32, 31);
        queue_cmd(2'd3, 21, 42);
        queue_cmd(OP_SEARCH, 0, 0);
        queue_cmd(OP_CLEAR, 0, 0);
        for (int k = 1; k < 32; k++)
            queue_cmd(OP_ADD, k, k + 1);
        queue_cmd(OP_ADD, 32, 1);
        queue_cmd(OP_SEARCH, 0, 0);
        drain();

        // Lower node count after loading, then the extremes
        write_node_count(4);
        queue_cmd(OP_SEARCH, 0, 0);
        queue_cmd(OP_ADD, 4, 5);
        queue_cmd(OP_SEARCH, 0, 0);
        drain();
        write_node_count(0);
        queue_cmd(OP_ADD, 1, 2);
        queue_cmd(OP_SEARCH, 0, 0);
        drain();
        write_node_count(63);
        queue_cmd(OP_CLEAR, 0, 0);
        for (int k = 0; k < 70; k++)
            queue_cmd(OP_ADD, $urandom_range(1, 32), $urandom_range(1, 32));
        queue_cmd(OP_SEARCH, 0, 0);
        drain();

        // Random graphs across several node counts
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_node_count(1);
                1: write_node_count(3);
                2: write_node_count($urandom_range(4, 31));
                3: write_node_count(32);
                default: write_node_count($urandom_range(33, 63));
            endcase
            quiet_mode = (phase == 3);
            span = nodes_active();
            for (int g = 0; g < 5; g++)
                queue_graph((span < 2) ? 2 : $urandom_range(2, (span > 8) ? 8 : span),
                            $urandom_range(1, 10));
            drain();
        end
        quiet_mode = 0;

        if (errors == 0)
            $display("undirected_cycle_finder regression: pass");
        else
            $display("undirected_cycle_finder regression: fail");
        $finish;
    end
endmodule

### sim.f
design/ucf_pkg.sv
design/ucf_ctrl.sv
design/ucf_datapath.sv
design/undirected_cycle_finder.sv
tb/tb_undirected_cycle_finder.sv
